[sv/ffba_pkg.sv]
// Shared types and constants for the first-fit block allocator.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package ffba_pkg;

    typedef enum logic [1:0] {
        ST_ALLOCATED = 2'd0,
        ST_NO_FIT    = 2'd1,
        ST_FREED     = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam int SIZE_W   = 9;
    localparam int INDEX_W  = 8;
    localparam int START_W  = 9;
    localparam int STATUS_W = 2;

    localparam logic [START_W-1:0] NO_BLOCK         = 9'h1FF;
    localparam logic [SIZE_W-1:0]  NUM_BLOCKS_RESET = 9'd256;

    // One pool entry: free flag and the run length held at a run start.
    typedef struct packed {
        logic              free;
        logic [SIZE_W-1:0] len;
    } entry_t;

    typedef struct packed {
        logic    clear;
        logic    load;
        logic    scan;
        logic    fread;
        logic    fstart;
        logic    write;
        logic    write_free;
        logic    emit;
        status_t code;
    } cmd_t;

    typedef struct packed {
        logic req_free;
        logic clear_last;
        logic scan_hit;
        logic scan_end;
        logic free_ok;
        logic write_last;
        logic out_busy;
    } stat_t;

endpackage

[sv/ffba_channels.sv]
// Valid/ready channel interfaces of the first-fit block allocator.
// Depends on ffba_pkg for the field widths.
interface ffba_req_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [ffba_pkg::SIZE_W-1:0]  request_size;
    logic [ffba_pkg::INDEX_W-1:0] start_index;

    modport source (output valid, action, request_size, start_index, input ready);
    modport sink   (input valid, action, request_size, start_index, output ready);
endinterface

interface ffba_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [ffba_pkg::START_W-1:0] start_block;
    logic [ffba_pkg::STATUS_W-1:0]       status;

    modport source (output valid, start_block, status, input ready);
    modport sink   (input valid, start_block, status, output ready);
endinterface

interface ffba_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [ffba_pkg::SIZE_W-1:0] num_blocks;

    modport source (output valid, num_blocks, input ready);
    modport sink   (input valid, num_blocks, output ready);
endinterface

[sv/ffba_ctrl.sv]
// Sequencing state machine of the first-fit block allocator.
// Depends on ffba_pkg for the command and status structs.
module ffba_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  ffba_pkg::stat_t stat,
    output ffba_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREAD,
        S_FCHECK,
        S_WRITE,
        S_RESP
    } state_t;

    state_t            state_reg, state_next;
    ffba_pkg::status_t code_reg, code_next;
    logic              free_reg, free_next;

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        free_next      = free_reg;
        cmd            = '0;
        cmd.code       = code_reg;
        cmd.write_free = free_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    free_next  = stat.req_free;
                    state_next = stat.req_free ? S_FREAD : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_hit)
                begin
                    code_next  = ffba_pkg::ST_ALLOCATED;
                    state_next = S_WRITE;
                end
                else if (stat.scan_end)
                begin
                    code_next  = ffba_pkg::ST_NO_FIT;
                    state_next = S_RESP;
                end
            end
            S_FREAD:
            begin
                cmd.fread  = 1'b1;
                state_next = S_FCHECK;
            end
            S_FCHECK:
            begin
                if (stat.free_ok)
                begin
                    cmd.fstart = 1'b1;
                    code_next  = ffba_pkg::ST_FREED;
                    state_next = S_WRITE;
                end
                else
                begin
                    code_next  = ffba_pkg::ST_IGNORED;
                    state_next = S_RESP;
                end
            end
            S_WRITE:
            begin
                cmd.write = 1'b1;
                if (stat.write_last)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                // The result register may still hold the previous beat.
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            code_reg  <= ffba_pkg::ST_NO_FIT;
            free_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            code_reg  <= code_next;
            free_reg  <= free_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);

endmodule

[sv/ffba_datapath.sv]
// Pool memory, scan counters, configuration and result register of the allocator.
// Depends on ffba_pkg; driven by ffba_ctrl through cmd_t and answers with stat_t.
module ffba_datapath #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_action,
    input  logic [ffba_pkg::SIZE_W-1:0]         req_size,
    input  logic [ffba_pkg::INDEX_W-1:0]        req_index,
    input  logic                                cfg_write,
    input  logic [ffba_pkg::SIZE_W-1:0]         cfg_data,
    input  logic                                rsp_ready,
    output logic                                rsp_valid,
    output logic signed [ffba_pkg::START_W-1:0] rsp_start_block,
    output logic [ffba_pkg::STATUS_W-1:0]       rsp_status,
    input  ffba_pkg::cmd_t                      cmd,
    output ffba_pkg::stat_t                     stat
);

    localparam int AW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = (AW + 1 > ffba_pkg::SIZE_W + 1) ? AW + 1 : ffba_pkg::SIZE_W + 1;
    localparam logic [CW-1:0] MAX_C  = CW'(MAX_BLOCKS);
    localparam logic [CW-1:0] LAST_C = CW'(MAX_BLOCKS - 1);

    ffba_pkg::entry_t mem [MAX_BLOCKS];
    ffba_pkg::entry_t rd_data_reg;

    logic [ffba_pkg::SIZE_W-1:0]  num_blocks_reg;
    logic [CW-1:0]                addr_reg;
    logic                         rd_vld_reg;
    logic [CW-1:0]                rd_pos_reg;
    logic [ffba_pkg::SIZE_W-1:0]  run_reg;
    logic [ffba_pkg::SIZE_W-1:0]  req_n_reg;
    logic [ffba_pkg::INDEX_W-1:0] idx_reg;
    logic [ffba_pkg::SIZE_W-1:0]  len_reg;
    logic [CW-1:0]                wr_addr_reg;
    logic [ffba_pkg::SIZE_W-1:0]  wr_cnt_reg;
    logic [CW-1:0]                start_reg;
    logic                         rsp_valid_reg;
    logic [ffba_pkg::START_W-1:0] rsp_start_reg;
    ffba_pkg::status_t            rsp_status_reg;

    logic [CW-1:0]               size;
    logic [CW-1:0]               idx_ext;
    logic [CW-1:0]               hit_start;
    logic                        scan_in_pool;
    logic [ffba_pkg::SIZE_W:0]   run_plus;
    logic [ffba_pkg::SIZE_W:0]   wr_cnt_plus;
    logic                        hit;
    logic                        idx_in_pool;
    logic                        rd_en;
    logic [AW-1:0]               rd_addr;
    logic                        wr_en;
    logic [AW-1:0]               wr_index;
    ffba_pkg::entry_t            wr_data;

    // A register value above the pool depth is capped at the depth.
    assign size = (CW'(num_blocks_reg) > MAX_C) ? MAX_C : CW'(num_blocks_reg);

    assign idx_ext      = CW'(idx_reg);
    assign idx_in_pool  = idx_ext < size;
    assign scan_in_pool = addr_reg < size;
    assign run_plus     = {1'b0, run_reg} + 1'b1;
    assign wr_cnt_plus  = {1'b0, wr_cnt_reg} + 1'b1;
    // The run ends at the block whose data is being checked now.
    assign hit          = rd_vld_reg && rd_data_reg.free && (run_plus == {1'b0, req_n_reg});
    assign hit_start    = rd_pos_reg + CW'(1) - CW'(req_n_reg);

    always_comb
    begin
        stat.req_free   = (req_action == ffba_pkg::ACT_FREE);
        stat.clear_last = (addr_reg == LAST_C);
        stat.scan_hit   = hit;
        stat.scan_end   = !rd_vld_reg && !scan_in_pool;
        stat.free_ok    = idx_in_pool && !rd_data_reg.free && (rd_data_reg.len != '0);
        stat.write_last = (wr_cnt_plus == {1'b0, len_reg}) || (wr_addr_reg == LAST_C);
        stat.out_busy   = rsp_valid_reg && !rsp_ready;
    end

    always_comb
    begin
        rd_en    = (cmd.scan && scan_in_pool) || (cmd.fread && idx_in_pool);
        rd_addr  = cmd.fread ? idx_ext[AW-1:0] : addr_reg[AW-1:0];
        wr_en    = cmd.clear || cmd.write;
        wr_index = cmd.clear ? addr_reg[AW-1:0] : wr_addr_reg[AW-1:0];
        wr_data  = '{free: 1'b0, len: '0};
        if (cmd.clear || cmd.write_free)
        begin
            wr_data.free = 1'b1;
        end
        else if (wr_cnt_reg == '0)
        begin
            wr_data.len = req_n_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_index] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_blocks_reg <= ffba_pkg::NUM_BLOCKS_RESET;
            addr_reg       <= '0;
            rd_vld_reg     <= 1'b0;
            rd_pos_reg     <= '0;
            run_reg        <= '0;
            req_n_reg      <= '0;
            idx_reg        <= '0;
            len_reg        <= '0;
            wr_addr_reg    <= '0;
            wr_cnt_reg     <= '0;
            start_reg      <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_start_reg  <= ffba_pkg::NO_BLOCK;
            rsp_status_reg <= ffba_pkg::ST_NO_FIT;
        end
        else
        begin
            if (cfg_write)
            begin
                num_blocks_reg <= cfg_data;
            end
            if (cmd.clear)
            begin
                addr_reg <= addr_reg + 1'b1;
            end
            if (cmd.load)
            begin
                req_n_reg  <= req_size;
                len_reg    <= req_size;
                idx_reg    <= req_index;
                addr_reg   <= '0;
                rd_vld_reg <= 1'b0;
                run_reg    <= '0;
            end
            if (cmd.scan)
            begin
                if (scan_in_pool)
                begin
                    addr_reg <= addr_reg + 1'b1;
                end
                rd_vld_reg <= scan_in_pool;
                rd_pos_reg <= addr_reg;
                if (rd_vld_reg)
                begin
                    run_reg <= rd_data_reg.free ? run_plus[ffba_pkg::SIZE_W-1:0] : '0;
                end
                if (hit)
                begin
                    wr_addr_reg <= hit_start;
                    start_reg   <= hit_start;
                    wr_cnt_reg  <= '0;
                end
            end
            if (cmd.fstart)
            begin
                len_reg     <= rd_data_reg.len;
                wr_addr_reg <= idx_ext;
                wr_cnt_reg  <= '0;
            end
            if (cmd.write)
            begin
                wr_addr_reg <= wr_addr_reg + 1'b1;
                wr_cnt_reg  <= wr_cnt_plus[ffba_pkg::SIZE_W-1:0];
            end
            if (cmd.emit)
            begin
                rsp_valid_reg  <= 1'b1;
                rsp_status_reg <= cmd.code;
                rsp_start_reg  <= (cmd.code == ffba_pkg::ST_ALLOCATED) ?
                                  start_reg[ffba_pkg::START_W-1:0] : ffba_pkg::NO_BLOCK;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid       = rsp_valid_reg;
    assign rsp_start_block = $signed(rsp_start_reg);
    assign rsp_status      = rsp_status_reg;

    a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(rsp_valid_reg && !rsp_ready))
        else $error("result loaded over a beat that was not taken");

    a_no_block_unless_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_status_reg != ffba_pkg::ST_ALLOCATED)
        |-> rsp_start_reg == ffba_pkg::NO_BLOCK)
        else $error("start block given on a result that is not an allocation");

    a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.write |-> wr_addr_reg < MAX_C)
        else $error("run write beyond the pool");

    a_hit_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan && hit) |-> (rd_pos_reg + CW'(1)) >= CW'(req_n_reg))
        else $error("found run starts before block zero");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear, cmd.load, cmd.scan, cmd.fread, cmd.fstart, cmd.write, cmd.emit}))
        else $error("more than one datapath command at once");

endmodule

[sv/first_fit_block_allocator_core.sv]
// First-fit contiguous block allocator.
// Channels: req carries one request beat (action, request_size, start_index); rsp
// returns exactly one beat per request (start_block, status); cfg writes num_blocks,
// and is always ready.
// An allocate scans the pool from block 0, one entry per cycle through the
// read port of the pool memory, for the first run of request_size free blocks, then
// writes the run one entry per cycle; with no fit the scan stops at the pool end.
// A free reads the entry at start_index, checks that a run starts there within the
// pool, then rewrites the run as free; an ignored free writes nothing.
// One request is in progress at a time; req is ready again once the result
// has been loaded into the rsp register.
// After reset a clearing pass over every pool entry marks every block free; req
// stays low meanwhile, while cfg writes are taken.
// When the receiver stalls, the result waits in the rsp register; the next request
// is still accepted and worked on, and its result waits until rsp is taken.
// Depends on ffba_pkg, ffba_channels, ffba_ctrl and ffba_datapath.
module first_fit_block_allocator_core #(
    parameter int MAX_BLOCKS = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    ffba_req_if.sink   req,
    ffba_rsp_if.source rsp,
    ffba_cfg_if.sink   cfg
);

    ffba_pkg::cmd_t  cmd;
    ffba_pkg::stat_t stat;
    logic            req_ready;

    ffba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ffba_datapath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_action      (req.action),
        .req_size        (req.request_size),
        .req_index       (req.start_index),
        .cfg_write       (cfg.valid),
        .cfg_data        (cfg.num_blocks),
        .rsp_ready       (rsp.ready),
        .rsp_valid       (rsp.valid),
        .rsp_start_block (rsp.start_block),
        .rsp_status      (rsp.status),
        .cmd             (cmd),
        .stat            (stat)
    );

    assign req.ready = req_ready;
    assign cfg.ready = 1'b1;

endmodule

[tb/ffba_result_checker.sv]
// Result checker for the first-fit block allocator: tracks the pool, predicts each response
// and compares it with what the block returns. Depends on ffba_pkg and ffba_channels.
module ffba_result_checker #(
    parameter int POOL_DEPTH = 256
) (
    input  logic clk,
    input  logic rst_n,
    ffba_req_if  req,
    ffba_rsp_if  rsp,
    ffba_cfg_if  cfg,
    output int   mismatches,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ffba_pkg::START_W-1:0] start;
        ffba_pkg::status_t            status;
    } outcome_t;

    bit                          block_is_free [POOL_DEPTH];
    bit [ffba_pkg::SIZE_W-1:0]   run_len [POOL_DEPTH];
    bit [ffba_pkg::SIZE_W-1:0]   pool_reg;
    outcome_t                    awaited_results [$];
    outcome_t                    head;
    int                          fail_total = 0;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_total++;
    endtask

    task automatic clear_pool();
        for (int i = 0; i < POOL_DEPTH; i++)
        begin
            block_is_free[i] = 1'b1;
            run_len[i] = '0;
        end
        pool_reg = ffba_pkg::NUM_BLOCKS_RESET;
    endtask

    // Applies one request to the pool copy and queues the response it should give.
    task automatic allocate_or_free(input logic act, input logic [ffba_pkg::SIZE_W-1:0] n,
                                    input logic [ffba_pkg::INDEX_W-1:0] idx);
        int       span;
        int       want;
        int       len;
        bit       found;
        bit       clear_run;
        outcome_t res;
        span = (int'(pool_reg) > POOL_DEPTH) ? POOL_DEPTH : int'(pool_reg);
        want = int'(n);
        found = 1'b0;
        res.start = ffba_pkg::NO_BLOCK;
        if (act == ffba_pkg::ACT_ALLOC)
        begin
            res.status = ffba_pkg::ST_NO_FIT;
            if (want != 0 && want <= span)
            begin
                for (int pos = 0; pos + want <= span && !found; pos++)
                begin
                    clear_run = 1'b1;
                    for (int k = 0; k < want && clear_run; k++)
                        if (!block_is_free[pos + k])
                            clear_run = 1'b0;
                    if (clear_run)
                    begin
                        for (int k = 0; k < want; k++)
                        begin
                            block_is_free[pos + k] = 1'b0;
                            run_len[pos + k] = '0;
                        end
                        run_len[pos] = n;
                        res.start = pos[ffba_pkg::START_W-1:0];
                        res.status = ffba_pkg::ST_ALLOCATED;
                        found = 1'b1;
                    end
                end
            end
        end
        else
        begin
            res.status = ffba_pkg::ST_IGNORED;
            if (int'(idx) < span && !block_is_free[idx] && run_len[idx] != 0)
            begin
                // A run that reaches past a shrunk pool is still released in full.
                len = int'(run_len[idx]);
                for (int k = 0; k < len && int'(idx) + k < POOL_DEPTH; k++)
                begin
                    block_is_free[int'(idx) + k] = 1'b1;
                    run_len[int'(idx) + k] = '0;
                end
                res.status = ffba_pkg::ST_FREED;
            end
        end
        awaited_results.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_pool();
            awaited_results.delete();
            pending <= 0;
            mismatches <= 0;
        end
        else
        begin
            // Responses are taken before new requests; a request never answers in its own cycle.
            if (rsp.valid && rsp.ready)
            begin
                if (awaited_results.size() == 0)
                    report_mismatch($sformatf("response beat start=%0d status=%0d with none awaited",
                                              rsp.start_block, rsp.status));
                else
                begin
                    head = awaited_results.pop_front();
                    if (rsp.start_block !== head.start)
                        report_mismatch($sformatf("start_block %0d, predicted %0d",
                                                  rsp.start_block, $signed(head.start)));
                    if (rsp.status !== head.status)
                        report_mismatch($sformatf("status %0d, predicted %s",
                                                  rsp.status, head.status.name()));
                end
            end
            if (cfg.valid && cfg.ready)
                pool_reg = cfg.num_blocks;
            if (req.valid && req.ready)
                allocate_or_free(req.action, req.request_size, req.start_index);
            pending <= awaited_results.size();
            mismatches <= fail_total;
        end
    end
endmodule

[tb/testbench.sv]
// Top of the first-fit block allocator testbench: clock, reset, request and config stimulus,
// receiver stalls, watchdog and verdict. Depends on ffba_pkg, ffba_channels,
// first_fit_block_allocator_core and ffba_result_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES     = 700;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int ITEMS_PER_PHASE = 93;
    localparam int SETTLE_CYCLES   = 300;

    logic clk;
    logic rst_n;
    int   mismatch_count;
    int   results_pending;
    bit   gaps_off;
    bit   stall_rsp_now;
    int   pool_span_now;
    logic [ffba_pkg::INDEX_W-1:0] live_runs [$];
    int   pool_plan [10] = '{2, 16, 511, 0, 40, 1, 256, 300, 8, 64};

    ffba_req_if req_ch ();
    ffba_rsp_if rsp_ch ();
    ffba_cfg_if cfg_ch ();

    first_fit_block_allocator_core #(.MAX_BLOCKS(256)) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    ffba_result_checker #(.POOL_DEPTH(256)) checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg        (cfg_ch),
        .mismatches (mismatch_count),
        .pending    (results_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_req(input logic act, input logic [ffba_pkg::SIZE_W-1:0] n,
                            input logic [ffba_pkg::INDEX_W-1:0] idx);
        int g;
        req_ch.valid        <= 1'b1;
        req_ch.action       <= act;
        req_ch.request_size <= n;
        req_ch.start_index  <= idx;
        do
            @(posedge clk);
        while (!req_ch.ready);
        g = gaps_off ? 0 : pick_gap();
        if (g > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic alloc_req(input logic [ffba_pkg::SIZE_W-1:0] n);
        send_req(ffba_pkg::ACT_ALLOC, n, ffba_pkg::INDEX_W'($urandom_range(0, 255)));
    endtask

    task automatic free_req(input logic [ffba_pkg::INDEX_W-1:0] idx);
        send_req(ffba_pkg::ACT_FREE, ffba_pkg::SIZE_W'($urandom_range(0, 511)), idx);
    endtask

    // The pool size is only changed once every response is back.
    task automatic set_pool(input logic [ffba_pkg::SIZE_W-1:0] blocks);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.num_blocks <= blocks;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        pool_span_now = (int'(blocks) > 256) ? 256 : int'(blocks);
    endtask

    // Mostly allocations and frees of runs known to be live, with some malformed requests.
    task automatic issue_random();
        int r;
        int cap;
        int pick;
        logic [ffba_pkg::SIZE_W-1:0]  n;
        logic [ffba_pkg::INDEX_W-1:0] idx;
        r   = $urandom_range(0, 99);
        n   = ffba_pkg::SIZE_W'($urandom_range(0, 511));
        idx = ffba_pkg::INDEX_W'($urandom_range(0, 255));
        cap = (pool_span_now / 3 < 1) ? 1 : pool_span_now / 3;
        if (r < 55)
        begin
            r = $urandom_range(0, 99);
            if (r < 80)
                n = ffba_pkg::SIZE_W'($urandom_range(1, cap));
            else if (r < 88)
                n = '0;
            else if (r < 95)
                n = ffba_pkg::SIZE_W'(pool_span_now + $urandom_range(0, 1));
            send_req(ffba_pkg::ACT_ALLOC, n, idx);
        end
        else if (r < 92)
        begin
            if (live_runs.size() > 0 && $urandom_range(0, 9) < 8)
            begin
                pick = $urandom_range(0, live_runs.size() - 1);
                idx  = live_runs[pick];
                live_runs.delete(pick);
                if ($urandom_range(0, 9) == 0)
                    idx = idx + 1'b1;
            end
            send_req(ffba_pkg::ACT_FREE, n, idx);
        end
        else
            send_req(logic'($urandom_range(0, 1)), n, idx);
    endtask

    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready && rsp_ch.status == ffba_pkg::ST_ALLOCATED)
            live_runs.push_back(rsp_ch.start_block[ffba_pkg::INDEX_W-1:0]);
    end

    initial
    begin
        int g;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            if (stall_rsp_now)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                stall_rsp_now = 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                g = gaps_off ? 0 : pick_gap();
                if (g > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    repeat (g) @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.action       <= ffba_pkg::ACT_ALLOC;
        req_ch.request_size <= '0;
        req_ch.start_index  <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.num_blocks   <= '0;
        gaps_off      = 1'b0;
        stall_rsp_now = 1'b0;
        pool_span_now = 256;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Full pool after reset: zero and oversize requests, whole pool, last start position.
        alloc_req(9'd0);
        alloc_req(9'd511);
        alloc_req(9'd257);
        alloc_req(9'd256);
        free_req(8'd255);
        free_req(8'd0);
        free_req(8'd0);
        alloc_req(9'd1);
        alloc_req(9'd3);
        alloc_req(9'd252);
        free_req(8'd1);
        alloc_req(9'd2);
        alloc_req(9'd1);
        free_req(8'd4);

        // Shrunk pool: a run beyond the bound is unreachable, one across it is freed whole.
        set_pool(9'd2);
        free_req(8'd3);
        free_req(8'd1);
        alloc_req(9'd1);
        alloc_req(9'd2);

        set_pool(9'd0);
        alloc_req(9'd1);
        free_req(8'd0);

        // Register above the pool depth is clamped.
        set_pool(9'd511);
        free_req(8'd3);
        alloc_req(9'd256);
        free_req(8'd1);
        free_req(8'd0);
        alloc_req(9'd256);

        pool_plan[9] = $urandom_range(2, 64);
        for (int ph = 0; ph < 10; ph++)
        begin
            set_pool(ffba_pkg::SIZE_W'(pool_plan[ph]));
            gaps_off = (ph == 1 || ph == 6);
            // The receiver holds off here while requests keep coming, so the input backs up.
            if (ph == 4)
                stall_rsp_now = 1'b1;
            repeat (ITEMS_PER_PHASE) issue_random();
        end

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (results_pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

[first_fit_block_allocator_core.f]
sv/ffba_pkg.sv
sv/ffba_channels.sv
sv/ffba_ctrl.sv
sv/ffba_datapath.sv
sv/first_fit_block_allocator_core.sv
tb/ffba_result_checker.sv
tb/testbench.sv
